// ===== sv/pidsrv_pkg.sv =====
// Shared types, constants and helper functions for the PID servo loop simulator.
// Used by the channel interface users, the multiply unit, the wrap unit and the top level.
package pidsrv_pkg;

  // Field widths of the command and response transactions, the tick counter and the register index.
  localparam int ANGLE_FIELD_W = 19;
  localparam int ERROR_FIELD_W = 20;
  localparam int WORD_W        = 32;
  localparam int TICK_W        = 24;
  localparam int CFG_INDEX_W   = 3;

  // 2*pi in unsigned Q32.32 and the clamp applied to every scaled product.
  localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;
  localparam logic [63:0] TERM_LIM   = 64'h2000_0000_0000_0000;

  // Register reset values.
  localparam logic [31:0] PROP_GAIN_RST       = 32'd6553600;
  localparam logic [31:0] INTEGRAL_GAIN_RST   = 32'd131072;
  localparam logic [31:0] DERIV_GAIN_RST      = 32'd32768;
  localparam logic [31:0] INVERSE_INERTIA_RST = 32'd3276800;
  localparam logic [31:0] DAMPING_RATIO_RST   = 32'd98304;
  localparam logic [31:0] STEP_SQUARED_RST    = 32'd4295;
  localparam logic [31:0] INVERSE_STEP_RST    = 32'd65536000;
  localparam logic [23:0] TICK_LIMIT_RST      = 24'd9001;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_INTEGRAL_GAIN   = 3'd1,
    REG_DERIV_GAIN      = 3'd2,
    REG_INVERSE_INERTIA = 3'd3,
    REG_DAMPING_RATIO   = 3'd4,
    REG_STEP_SQUARED    = 3'd5,
    REG_INVERSE_STEP    = 3'd6,
    REG_TICK_LIMIT      = 3'd7
  } cfg_reg_t;

  // Command transaction: one control tick.
  typedef struct packed {
    logic                     restart;
    logic [ANGLE_FIELD_W-1:0] initial_angle;
    logic [ANGLE_FIELD_W-1:0] target_angle;
  } cmd_t;

  // Response transaction: the plant state after the tick.
  typedef struct packed {
    logic [ANGLE_FIELD_W-1:0]        angle;
    logic signed [WORD_W-1:0]        velocity;
    logic signed [ERROR_FIELD_W-1:0] angle_error;
    logic signed [WORD_W-1:0]        torque;
    logic                            run_done;
  } rsp_t;

  // Request to the shared multiply unit: value times gain, shifted down.
  typedef struct packed {
    logic               start;
    logic               shift32;
    logic signed [63:0] value;
    logic [31:0]        gain;
  } mul_req_t;

  // Result of the shared multiply unit, valid while done is high.
  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } mul_rsp_t;

  // round(2*pi * 2^frac), for frac up to 31.
  function automatic logic [63:0] two_pi_fixed(input int frac);
    return (TWO_PI_Q32 + (64'd1 << (31 - frac))) >> (32 - frac);
  endfunction

  // Saturate a signed 64-bit value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/pidsrv_chan_if.sv =====
// Valid/ready channel carrying one payload struct per transaction.
// The payload type comes from pidsrv_pkg at the point of instantiation.
interface pidsrv_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pidsrv_mul_unit.sv =====
// Shared multiply unit: signed 64-bit value times unsigned 32-bit gain, shifted down,
// truncated toward zero and clamped to +-2^61. Uses one 32x32 multiplier; depends on pidsrv_pkg.
module pidsrv_mul_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pidsrv_pkg::mul_req_t req,
  output pidsrv_pkg::mul_rsp_t rsp
);
  import pidsrv_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_LO   = 5'b00010,
    M_HI   = 5'b00100,
    M_ADD  = 5'b01000,
    M_FIN  = 5'b10000
  } mul_state_t;

  mul_state_t         state;
  logic [63:0]        mag;
  logic               neg;
  logic [31:0]        gain;
  logic               shift32;
  logic [63:0]        prod;
  logic [95:0]        acc;
  logic               done;
  logic signed [63:0] res;

  logic [31:0]        mul_a;
  logic [63:0]        prod_next;
  logic [95:0]        shifted;
  logic [62:0]        clamped;
  logic signed [63:0] res_next;

  // One multiplier, fed with the low half and then the high half of the magnitude.
  assign mul_a     = (state == M_LO) ? mag[31:0] : mag[63:32];
  assign prod_next = 64'(mul_a) * 64'(gain);

  // Scale down, clamp the magnitude and restore the sign.
  always_comb begin
    shifted = shift32 ? (acc >> 32) : (acc >> FRAC_BITS);
    if (shifted > 96'(TERM_LIM)) begin
      clamped = TERM_LIM[62:0];
    end else begin
      clamped = shifted[62:0];
    end
    res_next = neg ? -$signed(64'(clamped)) : $signed(64'(clamped));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            mag     <= req.value[63] ? 64'(-req.value) : 64'(req.value);
            neg     <= req.value[63];
            gain    <= req.gain;
            shift32 <= req.shift32;
            state   <= M_LO;
          end
        end
        M_LO: begin
          prod  <= prod_next;
          state <= M_HI;
        end
        M_HI: begin
          acc <= 96'(prod);
          // The high partial product only matters for wide operands.
          if (|mag[63:32]) begin
            prod  <= prod_next;
            state <= M_ADD;
          end else begin
            state <= M_FIN;
          end
        end
        M_ADD: begin
          acc   <= acc + {prod, 32'd0};
          state <= M_FIN;
        end
        M_FIN: begin
          res   <= res_next;
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

// ===== sv/pidsrv_wrap_unit.sv =====
// Angle wrap unit: folds a signed 64-bit angle into [0, 2*pi] with a digit-serial
// remainder against the constant 2*pi, four bits per cycle. Depends on pidsrv_pkg.
module pidsrv_wrap_unit #(
  parameter int FRAC_BITS = 16,
  localparam logic [63:0] TWO_PI = pidsrv_pkg::two_pi_fixed(FRAC_BITS),
  localparam int ANGLE_W = $clog2(TWO_PI + 64'd1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] value,
  output logic               done,
  output logic [ANGLE_W-1:0] angle
);
  import pidsrv_pkg::*;

  localparam int DIGIT_BITS = 4;
  localparam int STEPS      = 64 / DIGIT_BITS;
  localparam int CNT_W      = $clog2(STEPS);
  localparam logic signed [63:0]   TWO_PI_S = TWO_PI;
  localparam logic [ANGLE_W:0]     DIV_EXT  = (ANGLE_W+1)'(TWO_PI);
  localparam logic [ANGLE_W-1:0]   DIV      = ANGLE_W'(TWO_PI);

  typedef enum logic [1:0] {
    W_IDLE = 2'b01,
    W_RUN  = 2'b10
  } wrap_state_t;

  wrap_state_t        state;
  logic [63:0]        dividend;
  logic [ANGLE_W-1:0] rem;
  logic               above;
  logic [CNT_W-1:0]   cnt;

  logic [ANGLE_W-1:0] rem_step;
  logic [63:0]        dividend_step;
  logic               in_range;

  assign in_range = !value[63] && (value <= TWO_PI_S);

  // Four restoring remainder steps per cycle.
  always_comb begin
    logic [ANGLE_W:0] trial;
    rem_step      = rem;
    dividend_step = dividend;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      trial = {rem_step, dividend_step[63]};
      if (trial >= DIV_EXT) begin
        trial = trial - DIV_EXT;
      end
      rem_step      = trial[ANGLE_W-1:0];
      dividend_step = {dividend_step[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        W_IDLE: begin
          if (start) begin
            if (in_range) begin
              angle <= value[ANGLE_W-1:0];
              done  <= 1'b1;
            end else begin
              // Above 2*pi the result is ((a-1) mod 2pi) + 1, below zero 2pi-1-((-a-1) mod 2pi).
              dividend <= value[63] ? 64'(-value - 64'sd1) : 64'(value - 64'sd1);
              above    <= !value[63];
              rem      <= '0;
              cnt      <= '0;
              state    <= W_RUN;
            end
          end
        end
        W_RUN: begin
          rem      <= rem_step;
          dividend <= dividend_step;
          cnt      <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(STEPS - 1)) begin
            angle <= above ? (rem_step + ANGLE_W'(1)) : (DIV - ANGLE_W'(1) - rem_step);
            done  <= 1'b1;
            state <= W_IDLE;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/pid_servo_loop_simulator.sv =====
// PID servo loop simulator top level: sequencer, registers, state and output register.
// Each tick runs eight multiplies on one shared 32x32 multiplier, plus a wrap when the new
// angle leaves [0, 2*pi] and a wrap of the initial angle on a restart. A new command is
// taken only in idle, after the previous tick is committed; the multiply unit is the bottleneck.
// Synchronous active-high reset loads register defaults and clears all servo state.
// Depends on pidsrv_pkg, pidsrv_chan_if, pidsrv_mul_unit and pidsrv_wrap_unit.
module pid_servo_loop_simulator #(
  parameter int FRAC_BITS = 16,
  parameter int SUM_WIDTH = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [pidsrv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pidsrv_pkg::WORD_W-1:0]        cfg_data,
  pidsrv_chan_if.sink                          cmd,
  pidsrv_chan_if.source                        rsp
);
  import pidsrv_pkg::*;

  localparam logic [63:0] TWO_PI  = two_pi_fixed(FRAC_BITS);
  localparam int          ANGLE_W = $clog2(TWO_PI + 64'd1);
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_RWRAP = 13'b0000000000010,
    ST_ERR   = 13'b0000000000100,
    ST_MP    = 13'b0000000001000,
    ST_MI    = 13'b0000000010000,
    ST_MD    = 13'b0000000100000,
    ST_MJ    = 13'b0000001000000,
    ST_MV    = 13'b0000010000000,
    ST_MA    = 13'b0000100000000,
    ST_WRAP  = 13'b0001000000000,
    ST_MS    = 13'b0010000000000,
    ST_ME    = 13'b0100000000000,
    ST_OUT   = 13'b1000000000000
  } seq_state_t;

  // Configuration registers.
  logic [31:0] prop_gain;
  logic [31:0] integral_gain;
  logic [31:0] deriv_gain;
  logic [31:0] inverse_inertia;
  logic [31:0] damping_ratio;
  logic [31:0] step_squared;
  logic [31:0] inverse_step;
  logic [TICK_W-1:0] tick_limit;

  // Servo state.
  logic [ANGLE_W-1:0]          cur_angle;
  logic signed [31:0]          cur_velocity;
  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [31:0]          last_error;
  logic signed [31:0]          error_slope;
  logic [TICK_W-1:0]           ticks_done;

  // Per-tick working registers.
  seq_state_t                 state;
  logic                       issued;
  logic [ANGLE_FIELD_W-1:0]   target;
  logic signed [31:0]         err;
  logic signed [63:0]         tsum;
  logic signed [31:0]         torque;
  logic signed [63:0]         accel;
  logic [ANGLE_W-1:0]         next_angle;
  logic signed [31:0]         vel_new;
  logic signed [31:0]         slope_new;
  logic                       out_valid;
  rsp_t                       out_data;

  // Unit connections.
  mul_req_t           mul_req;
  mul_rsp_t           mul_rsp;
  logic               wrap_start;
  logic signed [63:0] wrap_value;
  logic               wrap_done;
  logic [ANGLE_W-1:0] wrap_angle;

  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_next;
  logic [TICK_W-1:0]           ticks_next;
  logic [63:0]                 angle_wide;

  pidsrv_mul_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .req(mul_req),
    .rsp(mul_rsp)
  );

  pidsrv_wrap_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_wrap (
    .clk(clk),
    .rst(rst),
    .start(wrap_start),
    .value(wrap_value),
    .done(wrap_done),
    .angle(wrap_angle)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= PROP_GAIN_RST;
      integral_gain   <= INTEGRAL_GAIN_RST;
      deriv_gain      <= DERIV_GAIN_RST;
      inverse_inertia <= INVERSE_INERTIA_RST;
      damping_ratio   <= DAMPING_RATIO_RST;
      step_squared    <= STEP_SQUARED_RST;
      inverse_step    <= INVERSE_STEP_RST;
      tick_limit      <= TICK_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:       prop_gain       <= cfg_data;
        REG_INTEGRAL_GAIN:   integral_gain   <= cfg_data;
        REG_DERIV_GAIN:      deriv_gain      <= cfg_data;
        REG_INVERSE_INERTIA: inverse_inertia <= cfg_data;
        REG_DAMPING_RATIO:   damping_ratio   <= cfg_data;
        REG_STEP_SQUARED:    step_squared    <= cfg_data;
        REG_INVERSE_STEP:    inverse_step    <= cfg_data;
        REG_TICK_LIMIT:      tick_limit      <= cfg_data[TICK_W-1:0];
      endcase
    end
  end

  // Operand selection for the shared multiply unit.
  always_comb begin
    logic use_mul;
    use_mul         = 1'b1;
    mul_req.shift32 = 1'b0;
    mul_req.value   = '0;
    mul_req.gain    = '0;
    unique case (state)
      ST_MP: begin
        mul_req.value = 64'(err);
        mul_req.gain  = prop_gain;
      end
      ST_MI: begin
        mul_req.value = 64'(error_sum);
        mul_req.gain  = integral_gain;
      end
      ST_MD: begin
        mul_req.value = 64'(error_slope);
        mul_req.gain  = deriv_gain;
      end
      ST_MJ: begin
        mul_req.value = 64'(torque);
        mul_req.gain  = inverse_inertia;
      end
      ST_MV: begin
        mul_req.value = 64'(cur_velocity);
        mul_req.gain  = damping_ratio;
      end
      ST_MA: begin
        mul_req.value   = accel;
        mul_req.gain    = step_squared;
        mul_req.shift32 = 1'b1;
      end
      ST_MS: begin
        mul_req.value = $signed(64'(next_angle)) - $signed(64'(cur_angle));
        mul_req.gain  = inverse_step;
      end
      ST_ME: begin
        mul_req.value = 64'(err) - 64'(last_error);
        mul_req.gain  = inverse_step;
      end
      default: use_mul = 1'b0;
    endcase
    mul_req.start = use_mul && !issued;
  end

  // Wrap requests: the initial angle on restart, the moved angle after the plant step.
  always_comb begin
    wrap_start = 1'b0;
    wrap_value = '0;
    if (state == ST_IDLE) begin
      wrap_start = cmd.valid && cmd.data.restart;
      wrap_value = 64'(cmd.data.initial_angle);
    end else if (state == ST_MA) begin
      wrap_start = mul_rsp.done;
      wrap_value = $signed(64'(cur_angle)) + mul_rsp.res;
    end
  end

  // Saturating integral update and tick count.
  always_comb begin
    sum_wide = $signed({error_sum[SUM_WIDTH-1], error_sum}) + (SUM_WIDTH+1)'(err);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next = sum_wide[SUM_WIDTH-1:0];
    end
    ticks_next = (ticks_done == '1) ? ticks_done : ticks_done + TICK_W'(1);
    angle_wide = 64'(next_angle);
  end

  // Tick sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issued       <= 1'b0;
      out_valid    <= 1'b0;
      cur_angle    <= '0;
      cur_velocity <= '0;
      error_sum    <= '0;
      last_error   <= '0;
      error_slope  <= '0;
      ticks_done   <= '0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (mul_req.start) begin
        issued <= 1'b1;
      end else if (mul_rsp.done) begin
        issued <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            target <= cmd.data.target_angle;
            if (cmd.data.restart) begin
              cur_velocity <= '0;
              error_sum    <= '0;
              last_error   <= '0;
              error_slope  <= '0;
              ticks_done   <= '0;
              state        <= ST_RWRAP;
            end else begin
              state <= ST_ERR;
            end
          end
        end
        ST_RWRAP: begin
          if (wrap_done) begin
            cur_angle <= wrap_angle;
            state     <= ST_ERR;
          end
        end
        ST_ERR: begin
          err   <= $signed(32'(target)) - $signed(32'(cur_angle));
          state <= ST_MP;
        end
        ST_MP: begin
          if (mul_rsp.done) begin
            tsum  <= mul_rsp.res;
            state <= ST_MI;
          end
        end
        ST_MI: begin
          if (mul_rsp.done) begin
            tsum  <= tsum + mul_rsp.res;
            state <= ST_MD;
          end
        end
        ST_MD: begin
          if (mul_rsp.done) begin
            torque <= sat32(tsum + mul_rsp.res);
            state  <= ST_MJ;
          end
        end
        ST_MJ: begin
          if (mul_rsp.done) begin
            accel <= mul_rsp.res;
            state <= ST_MV;
          end
        end
        ST_MV: begin
          if (mul_rsp.done) begin
            accel <= accel - mul_rsp.res;
            state <= ST_MA;
          end
        end
        ST_MA: begin
          if (mul_rsp.done) begin
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (wrap_done) begin
            next_angle <= wrap_angle;
            state      <= ST_MS;
          end
        end
        ST_MS: begin
          if (mul_rsp.done) begin
            vel_new <= sat32(mul_rsp.res);
            state   <= ST_ME;
          end
        end
        ST_ME: begin
          if (mul_rsp.done) begin
            slope_new <= sat32(mul_rsp.res);
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Commit the tick once the output register is free.
          if (!out_valid || rsp.ready) begin
            out_data.angle       <= angle_wide[ANGLE_FIELD_W-1:0];
            out_data.velocity    <= vel_new;
            out_data.angle_error <= err[ERROR_FIELD_W-1:0];
            out_data.torque      <= torque;
            out_data.run_done    <= (ticks_next >= tick_limit);
            out_valid            <= 1'b1;
            cur_angle            <= next_angle;
            cur_velocity         <= vel_new;
            error_sum            <= sum_next;
            last_error           <= err;
            error_slope          <= slope_new;
            ticks_done           <= ticks_next;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign cmd.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // The stored angle always stays within [0, 2*pi].
  a_angle_in_range: assert property (@(posedge clk) disable iff (rst)
    64'(cur_angle) <= TWO_PI)
    else $error("stored angle above 2*pi");

  // A multiply result only arrives for an operation the sequencer issued.
  a_mul_done_issued: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> issued)
    else $error("multiply result without a pending request");

  // The wrap unit only finishes while the sequencer waits for it.
  a_wrap_done_waiting: assert property (@(posedge clk) disable iff (rst)
    wrap_done |-> (state == ST_RWRAP || state == ST_WRAP))
    else $error("wrap result arrived outside a wait state");

endmodule
